// File: rtl/sqch_pkg.sv
package sqch_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_ADVANCE  = 3'd1,
    CMD_ENVELOPE = 3'd2,
    CMD_LENGTH   = 3'd3,
    CMD_SWEEP    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SWEEP    = 3'd0,
    REG_LEN_DUTY = 3'd1,
    REG_VOL_ENV  = 3'd2,
    REG_PER_LO   = 3'd3,
    REG_PER_HI   = 3'd4
  } reg_e;

  localparam logic [11:0] PERIOD_LIMIT = 12'h7FF;
  localparam logic [11:0] PERIOD_BASE  = 12'd2048;
  localparam logic [6:0]  LENGTH_WRAP  = 7'd64;
  localparam logic [3:0]  VOL_MAX      = 4'd15;
  localparam logic [7:0]  ENV_DAC_MASK = 8'b1111_1000;
  localparam logic [7:0]  SWEEP_PACE_MASK = 8'b0111_0000;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] cycles;
  } item_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       channel_on;
    logic [2:0] duty_step;
  } result_t;

  // Standard duty patterns, step 0 is the MSB.
  function automatic logic duty_bit(logic [1:0] sel, logic [2:0] pos);
    logic [7:0] pat;
    unique case (sel)
      2'd0: pat = 8'h80;
      2'd1: pat = 8'h81;
      2'd2: pat = 8'hE1;
      default: pat = 8'h7E;
    endcase
    return pat[3'd7 - pos];
  endfunction

  // (2048 - period) * 4, range 4..8192
  function automatic logic [13:0] period_value(logic [10:0] raw);
    logic [11:0] diff;
    diff = PERIOD_BASE - {1'b0, raw};
    return {diff, 2'b00};
  endfunction

endpackage

// File: rtl/sqch_if.sv
interface sqch_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [2:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] cycles;
  modport source (output valid, command, reg_offset, write_data, cycles, input ready);
  modport sink   (input valid, command, reg_offset, write_data, cycles, output ready);
endinterface

interface sqch_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] sample;
  logic       channel_on;
  logic [2:0] duty_step;
  modport source (output valid, sample, channel_on, duty_step, input ready);
  modport sink   (input valid, sample, channel_on, duty_step, output ready);
endinterface

interface sqch_cfg_if;
  logic valid;
  logic ready;
  logic has_sweep;
  modport source (output valid, has_sweep, input ready);
  modport sink   (input valid, has_sweep, output ready);
endinterface

// File: rtl/sqch_core.sv
module sqch_core
  import sqch_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  item_t   item_i,
  input  logic    has_sweep_i,
  output result_t result_o
);

  logic [7:0]  sweep_reg_q, sweep_reg_d;
  logic [7:0]  len_duty_q, len_duty_d;
  logic [7:0]  vol_env_q, vol_env_d;
  logic [7:0]  per_lo_q, per_lo_d;
  logic [7:0]  per_hi_q, per_hi_d;
  logic        enabled_q, enabled_d;
  logic [2:0]  duty_pos_q, duty_pos_d;
  logic signed [15:0] countdown_q, countdown_d;
  logic [3:0]  volume_q, volume_d;
  logic        env_active_q, env_active_d;
  logic [3:0]  env_count_q, env_count_d;
  logic [5:0]  length_q, length_d;
  logic [2:0]  sweep_pace_q, sweep_pace_d;
  logic [2:0]  sweep_count_q, sweep_count_d;

  logic [10:0] raw_period;
  logic [13:0] pval;
  logic signed [17:0] adv_sub, adv_sum;
  logic        adv_wrap;
  logic [2:0]  env_pace;
  logic [4:0]  env_cnt;
  logic [4:0]  env_rem;
  logic [6:0]  len_next;
  logic [2:0]  sw_shift;
  logic [3:0]  sw_cnt;
  logic [10:0] sw_delta;
  logic [11:0] sw_new;
  logic [2:0]  sw_init;

  assign raw_period = {per_hi_q[2:0], per_lo_q};
  assign pval       = period_value(raw_period);

  // period timer, at most one reload per advance, saturating
  assign adv_sub  = {{2{countdown_q[15]}}, countdown_q} - signed'({10'd0, item_i.cycles});
  assign adv_wrap = adv_sub[17] || (adv_sub == 18'sd0);
  assign adv_sum  = adv_wrap ? adv_sub + signed'({4'd0, pval}) : adv_sub;

  assign env_pace = vol_env_q[2:0];
  assign env_cnt  = {1'b0, env_count_q} + 5'd1;
  assign env_rem  = env_cnt - {2'd0, env_pace};

  assign len_next = {1'b0, length_q} + 7'd1;

  assign sw_shift = sweep_reg_q[2:0];
  assign sw_cnt   = {1'b0, sweep_count_q} + 4'd1;
  assign sw_delta = raw_period >> sw_shift;
  assign sw_new   = sweep_reg_q[3] ? ({1'b0, raw_period} - {1'b0, sw_delta})
                                   : ({1'b0, raw_period} + {1'b0, sw_delta});
  assign sw_init  = item_i.write_data[6:4];

  always_comb begin
    sweep_reg_d   = sweep_reg_q;
    len_duty_d    = len_duty_q;
    vol_env_d     = vol_env_q;
    per_lo_d      = per_lo_q;
    per_hi_d      = per_hi_q;
    enabled_d     = enabled_q;
    duty_pos_d    = duty_pos_q;
    countdown_d   = countdown_q;
    volume_d      = volume_q;
    env_active_d  = env_active_q;
    env_count_d   = env_count_q;
    length_d      = length_q;
    sweep_pace_d  = sweep_pace_q;
    sweep_count_d = sweep_count_q;

    if (accept_i) begin
      unique case (item_i.command)
        CMD_WRITE: begin
          unique case (item_i.reg_offset)
            REG_SWEEP: begin
              if (has_sweep_i) begin
                sweep_reg_d = item_i.write_data;
                if (sw_init == 3'd0 || sweep_pace_q == 3'd0) begin
                  sweep_pace_d = sw_init;
                end
              end
            end
            REG_LEN_DUTY: begin
              len_duty_d = item_i.write_data;
              length_d   = item_i.write_data[5:0];
            end
            REG_VOL_ENV: vol_env_d = item_i.write_data;
            REG_PER_LO:  per_lo_d  = item_i.write_data;
            REG_PER_HI: begin
              per_hi_d = item_i.write_data;
              if (item_i.write_data[7]) begin
                enabled_d    = 1'b1;
                duty_pos_d   = 3'd0;
                // trigger uses the newly written high bits
                countdown_d  = signed'({2'b00,
                                        period_value({item_i.write_data[2:0], per_lo_q})});
                volume_d     = vol_env_q[7:4];
                env_active_d = 1'b1;
                if (has_sweep_i) begin
                  sweep_pace_d = sweep_reg_q[6:4];
                end
              end
              if (item_i.write_data[6]) begin
                length_d = len_duty_q[5:0];
              end
            end
            default: ;
          endcase
        end
        CMD_ADVANCE: begin
          if (enabled_q) begin
            if (adv_wrap) begin
              duty_pos_d = duty_pos_q + 3'd1;
            end
            if (adv_sum > 18'sd32767) begin
              countdown_d = 16'sh7FFF;
            end else if (adv_sum < -18'sd32768) begin
              countdown_d = 16'sh8000;
            end else begin
              countdown_d = adv_sum[15:0];
            end
          end
        end
        CMD_ENVELOPE: begin
          if ((vol_env_q & ENV_DAC_MASK) == 8'd0) begin
            enabled_d = 1'b0;
          end else if (env_cnt < {2'd0, env_pace}) begin
            env_count_d = env_cnt[3:0];
          end else if (env_pace == 3'd0 || !env_active_q) begin
            env_count_d = 4'd0;
          end else begin
            env_count_d = env_rem[3:0];
            if (vol_env_q[3]) begin
              if (volume_q == VOL_MAX) begin
                env_active_d = 1'b0;
              end else begin
                volume_d = volume_q + 4'd1;
              end
            end else begin
              if (volume_q == 4'd0) begin
                env_active_d = 1'b0;
              end else begin
                volume_d = volume_q - 4'd1;
              end
            end
          end
        end
        CMD_LENGTH: begin
          if (per_hi_q[6]) begin
            if (len_next >= LENGTH_WRAP) begin
              length_d  = 6'd0;
              enabled_d = 1'b0;
            end else begin
              length_d = len_next[5:0];
            end
          end
        end
        CMD_SWEEP: begin
          if (has_sweep_i) begin
            if (sw_shift == 3'd0 && sweep_pace_q == 3'd0) begin
              sweep_count_d = 3'd0;
            end else if (sw_cnt < {1'b0, sweep_pace_q}) begin
              sweep_count_d = sw_cnt[2:0];
            end else begin
              sweep_pace_d  = 3'((sweep_reg_q & SWEEP_PACE_MASK) >> 4);
              sweep_count_d = 3'd0;
              if (sw_new > PERIOD_LIMIT) begin
                enabled_d = 1'b0;
              end else begin
                per_hi_d = {per_hi_q[7:3], sw_new[10:8]};
                per_lo_d = sw_new[7:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_reg_q   <= '0;
      len_duty_q    <= '0;
      vol_env_q     <= '0;
      per_lo_q      <= '0;
      per_hi_q      <= '0;
      enabled_q     <= 1'b0;
      duty_pos_q    <= '0;
      countdown_q   <= '0;
      volume_q      <= '0;
      env_active_q  <= 1'b0;
      env_count_q   <= '0;
      length_q      <= '0;
      sweep_pace_q  <= '0;
      sweep_count_q <= '0;
    end else begin
      sweep_reg_q   <= sweep_reg_d;
      len_duty_q    <= len_duty_d;
      vol_env_q     <= vol_env_d;
      per_lo_q      <= per_lo_d;
      per_hi_q      <= per_hi_d;
      enabled_q     <= enabled_d;
      duty_pos_q    <= duty_pos_d;
      countdown_q   <= countdown_d;
      volume_q      <= volume_d;
      env_active_q  <= env_active_d;
      env_count_q   <= env_count_d;
      length_q      <= length_d;
      sweep_pace_q  <= sweep_pace_d;
      sweep_count_q <= sweep_count_d;
    end
  end

  // result reflects the state after this item
  assign result_o.sample     = (enabled_d && duty_bit(len_duty_d[7:6], duty_pos_d)) ?
                               volume_d : 4'd0;
  assign result_o.channel_on = enabled_d;
  assign result_o.duty_step  = duty_pos_d;

endmodule

// File: rtl/square_wave_sound_channel_unit.sv
// Channel  | Dir | Payload                                   | Handshake
// in_i     | in  | command, reg_offset, write_data, cycles   | valid/ready
// out_o    | out | sample, channel_on, duty_step             | valid/ready
// cfg_i    | in  | has_sweep                                 | valid/ready, ready tied high
//
// One item per clock while in_i.ready is high. Each accepted item updates the
// channel state, and its result is written to the output register at the same edge.
// in_i.ready drops only while a result sits in the output register and
// out_o.ready is low; a result taken in the same cycle frees the slot.
// Reset: channel off, all registers but the output payload zero, has_sweep set.
module square_wave_sound_channel_unit
  import sqch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sqch_in_if.sink    in_i,
  sqch_out_if.source out_o,
  sqch_cfg_if.sink   cfg_i
);

  logic    has_sweep_q;
  logic    accept;
  item_t   item;
  result_t result;
  result_t result_q;
  logic    out_valid_q;

  // config register; the user must write it only while idle, the block does not enforce this
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_sweep_q <= 1'b1;
    end else if (cfg_i.valid) begin
      has_sweep_q <= cfg_i.has_sweep;
    end
  end

  // output slot is free or being drained this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign item.command    = in_i.command;
  assign item.reg_offset = in_i.reg_offset;
  assign item.write_data = in_i.write_data;
  assign item.cycles     = in_i.cycles;

  sqch_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .has_sweep_i (has_sweep_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample     = result_q.sample;
  assign out_o.channel_on = result_q.channel_on;
  assign out_o.duty_step  = result_q.duty_step;

endmodule

// File: rtl/sqch_checker.sv
module sqch_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] sample_i,
  input logic       channel_on_i,
  input logic [2:0] duty_step_i
);

  // every accepted item yields a result next cycle
  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted item produced no result");

  // no backpressure while the output slot is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output slot");

  // a channel that is off is silent
  a_off_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !channel_on_i) |-> (sample_i == 4'd0))
    else $error("nonzero sample while channel off");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(sample_i) && $stable(channel_on_i) && $stable(duty_step_i)))
    else $error("result changed while stalled");

endmodule

bind square_wave_sound_channel_unit sqch_checker u_sqch_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sample_i     (out_o.sample),
  .channel_on_i (out_o.channel_on),
  .duty_step_i  (out_o.duty_step)
);

// File: tb/square_wave_sound_channel_unit_test.sv
module square_wave_sound_channel_unit_test;
  import sqch_pkg::*;

  // Codes past the last defined command and register: the block must
  // still answer them, without touching state.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Receiver back-pressure: a long hold-off at two points of the run, so
  // the output slot fills and the input stalls with the sender still busy.
  localparam int HOLD_AT_FIRST  = 150;
  localparam int HOLD_AT_SECOND = 480;
  localparam int HOLD_CYCLES    = 80;

  // ---------------------------------------------------------------------
  // Scoreboard: a shadow pulse channel. Every accepted item steps it once
  // and queues the sample it should report; results pop that queue.
  // ---------------------------------------------------------------------
  class pulse_scoreboard;
    bit       has_sweep = 1'b1;
    bit [7:0] sweep_r, len_duty_r, vol_env_r, per_lo_r, per_hi_r;
    bit       on;
    bit [2:0] step;
    int       countdown;
    bit [3:0] volume;
    bit       env_running;
    bit [3:0] env_ticks;
    bit [5:0] len_ticks;
    bit [2:0] sweep_pace, sweep_ticks;

    result_t  expected_samples[$];
    int       mismatches, checked, restarts, shutoffs, settings;
    int       cmd_count[8];

    // (2048 - eleven-bit period) * 4
    function int period_ticks();
      int raw;
      raw = {per_hi_r[2:0], per_lo_r};
      return (int'(PERIOD_BASE) - raw) * 4;
    endfunction

    function void write_reg(logic [2:0] offset, bit [7:0] v);
      case (offset)
        REG_SWEEP: begin
          if (has_sweep) begin
            sweep_r = v;
            // a running pace is only replaced by zero, or when idle
            if (v[6:4] == 3'd0 || sweep_pace == 3'd0) sweep_pace = v[6:4];
          end
        end
        REG_LEN_DUTY: begin
          len_duty_r = v;
          len_ticks  = v[5:0];
        end
        REG_VOL_ENV: vol_env_r = v;
        REG_PER_LO:  per_lo_r = v;
        REG_PER_HI: begin
          per_hi_r = v;
          if (v[7]) begin
            restarts++;
            on          = 1'b1;
            step        = 3'd0;
            countdown   = period_ticks();
            volume      = vol_env_r[7:4];
            env_running = 1'b1;
            if (has_sweep) sweep_pace = sweep_r[6:4];
          end
          if (v[6]) len_ticks = len_duty_r[5:0];
        end
        default: ;
      endcase
    endfunction

    function void advance(int cyc);
      int c;
      if (!on) return;
      c = countdown - cyc;
      if (c <= 0) begin
        c += period_ticks();
        step++;
      end
      if (c < -32768) c = -32768;
      if (c > 32767) c = 32767;
      countdown = c;
    endfunction

    function void envelope_tick();
      int pace, cnt, vol;
      pace = vol_env_r[2:0];
      // DAC off: volume bits and direction all zero
      if ((vol_env_r & ENV_DAC_MASK) == 8'd0) begin
        on = 1'b0;
        return;
      end
      cnt = env_ticks + 1;
      if (cnt < pace) begin
        env_ticks = 4'(cnt);
        return;
      end
      if (pace == 0 || !env_running) begin
        env_ticks = 4'd0;
        return;
      end
      env_ticks = 4'(cnt - pace);
      vol = int'(volume);
      if (vol_env_r[3]) vol++;
      else vol--;
      if (vol > int'(VOL_MAX) || vol < 0) begin
        vol = (vol > int'(VOL_MAX)) ? int'(VOL_MAX) : 0;
        env_running = 1'b0;
      end
      volume = 4'(vol);
    endfunction

    function void length_tick();
      int n;
      if (!per_hi_r[6]) return;
      n = len_ticks + 1;
      if (n >= int'(LENGTH_WRAP)) begin
        len_ticks = 6'd0;
        on = 1'b0;
      end else begin
        len_ticks = 6'(n);
      end
    endfunction

    function void sweep_tick();
      int shift, cnt, old_p, new_p;
      if (!has_sweep) return;
      shift = sweep_r[2:0];
      if (shift == 0 && sweep_pace == 3'd0) begin
        sweep_ticks = 3'd0;
        return;
      end
      cnt = sweep_ticks + 1;
      if (cnt < sweep_pace) begin
        sweep_ticks = 3'(cnt);
        return;
      end
      sweep_pace  = sweep_r[6:4];
      sweep_ticks = 3'd0;
      old_p = {per_hi_r[2:0], per_lo_r};
      new_p = sweep_r[3] ? old_p - (old_p >> shift) : old_p + (old_p >> shift);
      // overflow kills the channel and leaves the period alone
      if (new_p > int'(PERIOD_LIMIT)) begin
        on = 1'b0;
        return;
      end
      per_hi_r[2:0] = new_p[10:8];
      per_lo_r      = new_p[7:0];
    endfunction

    function result_t current_sample();
      result_t  r;
      bit [7:0] pat;
      // step 0 is the MSB of the pattern
      case (len_duty_r[7:6])
        2'd0:    pat = 8'h80;
        2'd1:    pat = 8'h81;
        2'd2:    pat = 8'hE1;
        default: pat = 8'h7E;
      endcase
      r.sample     = (on && pat[7 - step]) ? volume : 4'd0;
      r.channel_on = on;
      r.duty_step  = step;
      return r;
    endfunction

    function void take_command(item_t it);
      bit was_on;
      was_on = on;
      cmd_count[it.command]++;
      case (it.command)
        CMD_WRITE:    write_reg(it.reg_offset, it.write_data);
        CMD_ADVANCE:  advance(it.cycles);
        CMD_ENVELOPE: envelope_tick();
        CMD_LENGTH:   length_tick();
        CMD_SWEEP:    sweep_tick();
        default: ;
      endcase
      if (was_on && !on) shutoffs++;
      expected_samples.push_back(current_sample());
    endfunction

    function void compare_sample(result_t got);
      result_t want;
      checked++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: sample=%0d on=%0d step=%0d",
                   checked, got.sample, got.channel_on, got.duty_step);
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample !== want.sample || got.channel_on !== want.channel_on ||
          got.duty_step !== want.duty_step) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d (sample/on/step)",
                   checked, want.sample, want.channel_on, want.duty_step,
                   got.sample, got.channel_on, got.duty_step);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Block and its channels
  // ---------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  sqch_in_if  in_if();
  sqch_out_if out_if();
  sqch_cfg_if cfg_if();

  square_wave_sound_channel_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  pulse_scoreboard book = new();

  int items_sent;
  bit send_calm;  // sender offers back to back
  bit take_calm;  // receiver skips random stalls; the two long hold-offs still apply

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall per result, plus two long hold-offs counted here.
  // Ready moves at the falling edge, results are taken at the rising edge.
  // ---------------------------------------------------------------------
  initial begin : result_taker
    int      stall;
    result_t got;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (book.checked == HOLD_AT_FIRST || book.checked == HOLD_AT_SECOND)
        stall = HOLD_CYCLES;
      else
        stall = take_calm ? 0 : $urandom_range(0, 17);
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.sample     = out_if.sample;
      got.channel_on = out_if.channel_on;
      got.duty_step  = out_if.duty_step;
      book.compare_sample(got);
    end
  end

  // ---------------------------------------------------------------------
  // Sender. Must be called again (or stop_sending) right after it returns:
  // valid is left high and the next falling edge decides what follows.
  // ---------------------------------------------------------------------
  task automatic send_item(input item_t it);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= it.command;
    in_if.reg_offset <= it.reg_offset;
    in_if.write_data <= it.write_data;
    in_if.cycles     <= it.cycles;
    do @(posedge clk_i); while (!in_if.ready);
    book.take_command(it);
    items_sent++;
  endtask

  task automatic put(input logic [2:0] cmd, input logic [2:0] offset,
                     input logic [7:0] data, input logic [7:0] cyc);
    item_t it;
    it.command    = cmd;
    it.reg_offset = offset;
    it.write_data = data;
    it.cycles     = cyc;
    send_item(it);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Drain everything outstanding before a config write; every item yields
  // exactly one result, so an empty queue means the block is idle.
  task automatic settle();
    stop_sending();
    while (book.expected_samples.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_sweep_unit(input bit present);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.has_sweep <= present;
    do @(posedge clk_i); while (!cfg_if.ready);
    book.has_sweep = present;
    book.settings++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // One tick, write or unused command, weighted towards period steps and the frame ticks.
  function automatic item_t random_op();
    item_t it;
    int    pick;
    it   = 22'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      it.command = 3'($urandom_range(CMD_SWEEP + 1, CMD_UNUSED));
    end else if (pick < 18) begin
      it.command = CMD_WRITE;
      if ($urandom_range(0, 9) == 0)
        it.reg_offset = 3'($urandom_range(REG_PER_HI + 1, REG_UNUSED));
      else
        it.reg_offset = 3'($urandom_range(REG_SWEEP, REG_PER_HI));
    end else if (pick < 50) begin
      it.command = CMD_ADVANCE;
      if ($urandom_range(0, 2) == 0) it.cycles = 8'($urandom_range(0, 8));
    end else if (pick < 68) begin
      it.command = CMD_ENVELOPE;
    end else if (pick < 86) begin
      it.command = CMD_LENGTH;
    end else begin
      it.command = CMD_SWEEP;
    end
    return it;
  endfunction

  // Mostly: program all five registers, restart the channel, then run a
  // random burst of ticks and writes on it. Now and then skip the setup.
  task automatic random_phase(input int count);
    item_t it;
    int    goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) begin
        it = 22'($urandom);
        it.command = CMD_WRITE;
        it.reg_offset = REG_SWEEP;
        send_item(it);
        it.reg_offset = REG_LEN_DUTY;
        it.write_data = 8'($urandom);
        // short remaining length so expiry is reached often
        if ($urandom_range(0, 1)) it.write_data[5:0] = 6'($urandom_range(52, 63));
        send_item(it);
        it.reg_offset = REG_VOL_ENV;
        it.write_data = 8'($urandom);
        send_item(it);
        it.reg_offset = REG_PER_LO;
        it.write_data = 8'($urandom);
        send_item(it);
        it.reg_offset = REG_PER_HI;
        it.write_data = 8'($urandom);
        it.write_data[7] = 1'b1;
        // high periods give short countdowns, so the duty step moves
        if ($urandom_range(0, 1)) it.write_data[2:0] = 3'b111;
        send_item(it);
      end
      repeat ($urandom_range(8, 40)) send_item(random_op());
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    in_if.valid      = 1'b0;
    in_if.command    = CMD_WRITE;
    in_if.reg_offset = REG_SWEEP;
    in_if.write_data = 8'd0;
    in_if.cycles     = 8'd0;
    cfg_if.valid     = 1'b0;
    cfg_if.has_sweep = 1'b1;
    rst_ni           = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, sweep unit present (reset value).
    put(CMD_UNUSED,  REG_UNUSED,   8'hFF, 8'hFF); // unknown command
    put(CMD_ADVANCE, REG_SWEEP,    8'h00, 8'hFF); // advance while off
    put(CMD_WRITE,   REG_UNUSED,   8'hFF, 8'h00); // unknown register
    put(CMD_WRITE,   REG_LEN_DUTY, 8'hFE, 8'h00); // duty 3, length 62
    put(CMD_WRITE,   REG_VOL_ENV,  8'hF9, 8'h00); // vol 15, up, pace 1
    put(CMD_WRITE,   REG_PER_LO,   8'hFF, 8'h00);
    put(CMD_WRITE,   REG_SWEEP,    8'h71, 8'h00);
    put(CMD_WRITE,   REG_PER_HI,   8'hC7, 8'h00); // restart + length on
    put(CMD_ADVANCE, REG_SWEEP,    8'h00, 8'h00); // zero cycles
    put(CMD_ADVANCE, REG_SWEEP,    8'h00, 8'hFF); // wraps the countdown
    put(CMD_ENVELOPE, REG_SWEEP,   8'h00, 8'h00); // clamps at 15
    put(CMD_LENGTH,  REG_SWEEP,    8'h00, 8'h00);
    put(CMD_LENGTH,  REG_SWEEP,    8'h00, 8'h00); // length expires
    put(CMD_WRITE,   REG_VOL_ENV,  8'h11, 8'h00); // vol 1, down, pace 1
    put(CMD_WRITE,   REG_PER_HI,   8'h80, 8'h00); // restart, length off
    put(CMD_ENVELOPE, REG_SWEEP,   8'h00, 8'h00); // down to 0
    put(CMD_ENVELOPE, REG_SWEEP,   8'h00, 8'h00); // clamps at 0
    put(CMD_WRITE,   REG_VOL_ENV,  8'h00, 8'h00);
    put(CMD_ENVELOPE, REG_SWEEP,   8'h00, 8'h00); // DAC off kills channel
    put(CMD_WRITE,   REG_SWEEP,    8'h09, 8'h00); // pace 0, down, shift 1
    put(CMD_SWEEP,   REG_SWEEP,    8'h00, 8'h00);
    put(CMD_WRITE,   REG_SWEEP,    8'h00, 8'h00);
    put(CMD_SWEEP,   REG_SWEEP,    8'h00, 8'h00); // nothing to do
    put(CMD_WRITE,   REG_PER_HI,   8'h07, 8'h00);
    put(CMD_WRITE,   REG_SWEEP,    8'h11, 8'h00);
    put(CMD_SWEEP,   REG_SWEEP,    8'h00, 8'h00); // period overflow
    settle();

    set_sweep_unit(1'b0);
    random_phase(150);
    settle();
    set_sweep_unit(1'b1);
    random_phase(400);
    settle();
    set_sweep_unit(1'b0);
    random_phase(150);

    settle();
    repeat (10) @(posedge clk_i);

    $write("run covered %0d items: %0d writes (%0d restarts), %0d advances, ",
           items_sent, book.cmd_count[CMD_WRITE], book.restarts,
           book.cmd_count[CMD_ADVANCE]);
    $display("%0d envelope, %0d length, %0d sweep, %0d unused",
             book.cmd_count[CMD_ENVELOPE], book.cmd_count[CMD_LENGTH],
             book.cmd_count[CMD_SWEEP],
             book.cmd_count[5] + book.cmd_count[6] + book.cmd_count[7]);
    $write("%0d results checked, %0d mismatches, ", book.checked, book.mismatches);
    $display("%0d channel shutoffs, %0d sweep-unit settings",
             book.shutoffs, book.settings);
    if (book.mismatches == 0 && book.expected_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
